// ===== rtl/bd2a_pkg.sv =====
package bd2a_pkg;

   localparam int VALUE_BITS_DEFAULT = 64;
   localparam int DIGIT_BITS = 4;
   localparam int CHAR_BITS = 6;
   localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   // per-cycle command broadcast to every cell of the digit chain
   typedef struct packed {
      logic clear;
      logic dabble;
      logic shift_up;
   } cell_ctrl_type;

endpackage

// ===== rtl/binary_to_decimal_ascii.sv =====
// Unsigned binary to decimal ASCII converter.
// Request channel (req_valid / req_ready / req_value): one unsigned value, of
// which the low VALUE_BITS bits are converted. Response channel (rsp_valid /
// rsp_ready / rsp_digit_char / rsp_last): the decimal digits as ASCII codes,
// most significant first, leading zeros dropped, a zero value giving one '0'.
// rsp_last marks the least significant digit.
// Conversion runs on a chain of NUM_DIGITS BCD cells with shift-and-add-3,
// one input bit per cycle. The chain then shifts one digit toward the top
// per cycle while no response stall holds it; each leading zero is skipped
// by a shift, and each digit is emitted when the response register is free.
// req_ready is high only while no request is in work; the last digit
// may still wait in the response register while the next request is taken.
// A stalled receiver holds the chain in place once the first digit is out.
// Synchronous reset empties the response register and returns to idle.
module binary_to_decimal_ascii #(
   parameter int VALUE_BITS = bd2a_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [63:0]                     req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bd2a_pkg::CHAR_BITS-1:0]  rsp_digit_char,
   output logic                            rsp_last
);
   import bd2a_pkg::*;

   localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BW = $clog2(VALUE_BITS);
   localparam int CW = $clog2(NUM_DIGITS + 1);

   state_type state_ff, state_in;

   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [BW-1:0]         bit_cnt_ff, bit_cnt_in;
   logic [CW-1:0]         dig_cnt_ff, dig_cnt_in;
   logic                  started_ff, started_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]  rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   cell_ctrl_type         ctrl;
   logic                  accept;
   logic                  slot_free;
   logic                  skip;
   logic                  emit;
   logic [DIGIT_BITS-1:0] top_digit;

   logic [DIGIT_BITS-1:0] digit_q [NUM_DIGITS];
   logic                  carry_q [NUM_DIGITS];

   genvar gi;
   generate
      for (gi = 0; gi < NUM_DIGITS; gi++) begin : g_cell
         if (gi == 0) begin : g_first
            bd2a_cell u_cell (
               .clock     (clock),
               .ctrl      (ctrl),
               .carry_in  (val_ff[VALUE_BITS-1]),
               .digit_in  ({DIGIT_BITS{1'b0}}),
               .carry_out (carry_q[gi]),
               .digit_out (digit_q[gi])
            );
         end else begin : g_rest
            bd2a_cell u_cell (
               .clock     (clock),
               .ctrl      (ctrl),
               .carry_in  (carry_q[gi-1]),
               .digit_in  (digit_q[gi-1]),
               .carry_out (carry_q[gi]),
               .digit_out (digit_q[gi])
            );
         end
      end
   endgenerate

   assign top_digit = digit_q[NUM_DIGITS-1];
   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last = rsp_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (bit_cnt_ff == '0) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit && dig_cnt_ff == CW'(1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control and register updates
   always_comb begin
      skip = (state_ff == ST_EMIT) && !started_ff && (top_digit == '0) &&
             (dig_cnt_ff != CW'(1));
      emit = (state_ff == ST_EMIT) && !skip && slot_free;

      ctrl.clear    = accept;
      ctrl.dabble   = (state_ff == ST_CONVERT);
      ctrl.shift_up = skip || emit;

      val_in     = val_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      started_in = started_ff;
      if (accept) begin
         val_in     = req_value[VALUE_BITS-1:0];
         bit_cnt_in = BW'(VALUE_BITS - 1);
         dig_cnt_in = CW'(NUM_DIGITS);
         started_in = 1'b0;
      end else if (state_ff == ST_CONVERT) begin
         val_in     = {val_ff[VALUE_BITS-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - BW'(1);
      end else if (ctrl.shift_up) begin
         dig_cnt_in = dig_cnt_ff - CW'(1);
         if (emit) started_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = ASCII_ZERO + {{(CHAR_BITS-DIGIT_BITS){1'b0}}, top_digit};
         rsp_last_in  = (dig_cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      val_ff      <= val_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      started_ff  <= started_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTHESIS
   // the top cell never overflows: NUM_DIGITS covers the full value range
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT) |-> !carry_q[NUM_DIGITS-1])
      else $error("digit chain overflow");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_char_ff >= ASCII_ZERO) &&
                       (rsp_char_ff <= ASCII_ZERO + CHAR_BITS'(9)))
      else $error("response is not a decimal digit");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && dig_cnt_ff == CW'(1) && slot_free) |=>
         (state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff)
      else $error("final digit not flagged last");

   a_convert_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT && bit_cnt_ff == '0) |=>
         (state_ff == ST_EMIT) && (dig_cnt_ff == CW'(NUM_DIGITS)) && !started_ff)
      else $error("emit phase entered in a wrong state");
`endif

endmodule

// ===== rtl/bd2a_cell.sv =====
module bd2a_cell (
   input  logic                             clock,
   input  bd2a_pkg::cell_ctrl_type          ctrl,
   input  logic                             carry_in,
   input  logic [bd2a_pkg::DIGIT_BITS-1:0]  digit_in,
   output logic                             carry_out,
   output logic [bd2a_pkg::DIGIT_BITS-1:0]  digit_out
);
   import bd2a_pkg::*;

   logic [DIGIT_BITS-1:0] digit_ff;
   logic [DIGIT_BITS-1:0] digit_in_int;
   logic [DIGIT_BITS-1:0] adj;

   // add 3 before the shift so the doubled digit carries at 10
   assign adj = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign carry_out = adj[DIGIT_BITS-1];
   assign digit_out = digit_ff;

   always_comb begin
      digit_in_int = digit_ff;
      if (ctrl.clear) begin
         digit_in_int = '0;
      end else if (ctrl.dabble) begin
         digit_in_int = {adj[DIGIT_BITS-2:0], carry_in};
      end else if (ctrl.shift_up) begin
         digit_in_int = digit_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_int;
   end

endmodule
